@@ hw/rtl/dfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// Field widths, codes and shared types of the dataflow firing scheduler.
// ----------------------------------------------------------------------------
package dfs_pkg;

   localparam int ACTION_W   = 2;
   localparam int EIDX_W     = 4;
   localparam int ACTOR_W    = 3;
   localparam int RATE_IN_W  = 8;
   localparam int TOKEN_W    = 10;
   localparam int REPEAT_W   = 8;
   localparam int STATUS_W   = 3;
   localparam int CAP_W      = 11;
   localparam int EDGES_W    = 5;
   localparam int ACTORS_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [TOKEN_W-1:0] TOKEN_MAX    = 10'd1023;
   localparam logic [CAP_W-1:0]   CAP_LIMIT    = 11'd1024;
   localparam logic [CAP_W-1:0]   CAP_RESET    = 11'd16;
   localparam logic [EDGES_W-1:0] EDGES_RESET  = 5'd0;
   localparam logic [ACTORS_W-1:0] ACTORS_RESET = 4'd1;

   localparam logic [ACTION_W-1:0] ACTION_WRITE_EDGE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_WRITE_REPEAT = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_RESTART      = 2'd2;
   localparam logic [ACTION_W-1:0] ACTION_STEP         = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FIRED     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ITER_DONE = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FIFO_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGES_IN_USE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTORS_IN_USE = 2'd2;

   // Result of evaluating one edge against the actor under test
   typedef struct packed {
      logic               blocked;
      logic               over;
      logic [TOKEN_W-1:0] new_count;
   } edge_eval_type;

endpackage

@@ hw/rtl/dfs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_if
// Handshake channels of the scheduler: request, response and register write.
// ----------------------------------------------------------------------------
interface dfs_req_if;
   import dfs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [EIDX_W-1:0]    edge_index;
   logic [ACTOR_W-1:0]   edge_source;
   logic [ACTOR_W-1:0]   edge_target;
   logic [RATE_IN_W-1:0] produce_rate;
   logic [RATE_IN_W-1:0] consume_rate;
   logic [TOKEN_W-1:0]   initial_tokens;
   logic [ACTOR_W-1:0]   actor_index;
   logic [REPEAT_W-1:0]  repeat_count;

   modport source (output valid, action, edge_index, edge_source, edge_target,
                   produce_rate, consume_rate, initial_tokens, actor_index,
                   repeat_count, input ready);
   modport sink   (input valid, action, edge_index, edge_source, edge_target,
                   produce_rate, consume_rate, initial_tokens, actor_index,
                   repeat_count, output ready);
endinterface

interface dfs_rsp_if;
   import dfs_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ACTOR_W-1:0]  fired_actor;
   logic [REPEAT_W-1:0] firings_left;

   modport source (output valid, status, fired_actor, firings_left, input ready);
   modport sink   (input valid, status, fired_actor, firings_left, output ready);
endinterface

interface dfs_csr_if;
   import dfs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dfs_edge_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_edge_mem
// Edge table: endpoints, rates and token count, one registered read port.
// ----------------------------------------------------------------------------
module dfs_edge_mem #(
   parameter int DEPTH     = 16,
   parameter int ADDR_W    = 4,
   parameter int RATE_BITS = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [dfs_pkg::ACTOR_W-1:0] wr_src,
   input  logic [dfs_pkg::ACTOR_W-1:0] wr_dst,
   input  logic [RATE_BITS-1:0]        wr_push,
   input  logic [RATE_BITS-1:0]        wr_pop,
   input  logic                        cnt_wr_en,
   input  logic [ADDR_W-1:0]           cnt_wr_addr,
   input  logic [dfs_pkg::TOKEN_W-1:0] cnt_wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [dfs_pkg::ACTOR_W-1:0] rd_src,
   output logic [dfs_pkg::ACTOR_W-1:0] rd_dst,
   output logic [RATE_BITS-1:0]        rd_push,
   output logic [RATE_BITS-1:0]        rd_pop,
   output logic [dfs_pkg::TOKEN_W-1:0] rd_count
);
   import dfs_pkg::*;

   logic [ACTOR_W-1:0]   src_mem   [DEPTH];
   logic [ACTOR_W-1:0]   dst_mem   [DEPTH];
   logic [RATE_BITS-1:0] push_mem  [DEPTH];
   logic [RATE_BITS-1:0] pop_mem   [DEPTH];
   logic [TOKEN_W-1:0]   count_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         src_mem[wr_addr]  <= wr_src;
         dst_mem[wr_addr]  <= wr_dst;
         push_mem[wr_addr] <= wr_push;
         pop_mem[wr_addr]  <= wr_pop;
      end
      if (cnt_wr_en) begin
         count_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      rd_src   <= src_mem[rd_addr];
      rd_dst   <= dst_mem[rd_addr];
      rd_push  <= push_mem[rd_addr];
      rd_pop   <= pop_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
   end

endmodule

@@ hw/rtl/dfs_cnt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_cnt_ram
// Per-actor firing count store; entries never written read as zero.
// ----------------------------------------------------------------------------
module dfs_cnt_ram #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [dfs_pkg::REPEAT_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [dfs_pkg::REPEAT_W-1:0] rd_data
);
   import dfs_pkg::*;

   logic [REPEAT_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   logic [REPEAT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/dfs_edge_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_edge_alu
// Shared edge unit: token check for readiness and count update for a firing.
// ----------------------------------------------------------------------------
module dfs_edge_alu #(
   parameter int ACT_W     = 3,
   parameter int RATE_BITS = 8
) (
   input  logic [ACT_W-1:0]            actor,
   input  logic [dfs_pkg::ACTOR_W-1:0] src,
   input  logic [dfs_pkg::ACTOR_W-1:0] dst,
   input  logic [RATE_BITS-1:0]        push,
   input  logic [RATE_BITS-1:0]        pop,
   input  logic [dfs_pkg::TOKEN_W-1:0] count,
   input  logic [dfs_pkg::CAP_W-1:0]   cap,
   output dfs_pkg::edge_eval_type      eval
);
   import dfs_pkg::*;

   localparam int AW    = (ACT_W > ACTOR_W) ? ACT_W : ACTOR_W;
   localparam int NW    = (RATE_BITS > TOKEN_W) ? RATE_BITS : TOKEN_W;
   localparam int SUM_W = NW + 1;

   logic             src_hit;
   logic             dst_hit;
   logic [SUM_W-1:0] count_w;
   logic [SUM_W-1:0] pop_w;
   logic [SUM_W-1:0] after_pop;
   logic [SUM_W-1:0] after_push;

   assign src_hit = AW'(src) == AW'(actor);
   assign dst_hit = AW'(dst) == AW'(actor);
   assign count_w = SUM_W'(count);
   assign pop_w   = SUM_W'(pop);

   // pop never exceeds count when the actor fires, so no wrap here
   assign after_pop  = dst_hit ? count_w - pop_w : count_w;
   assign after_push = src_hit ? after_pop + SUM_W'(push) : after_pop;

   always_comb begin
      eval.blocked = dst_hit && (pop_w > count_w);
      eval.over    = src_hit && (after_push >= SUM_W'(cap));
      if (after_push > SUM_W'(TOKEN_MAX)) begin
         eval.new_count = TOKEN_MAX;
      end else begin
         eval.new_count = after_push[TOKEN_W-1:0];
      end
   end

endmodule

@@ hw/rtl/dataflow_firing_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dataflow_firing_scheduler
// Token-count scheduler for a synchronous dataflow graph, one actor a step.
// ----------------------------------------------------------------------------
// Usage: each request item on req_bus is an edge write, a repeat-count write,
// a restart or a step; each gives exactly one response item on rsp_bus
// (status, fired actor, firings left). csr_bus writes capacity, edges in use
// and actors in use; it is always ready. The user must see that it is written
// only while idle; the block does not enforce this. Timing: one item at a
// time; req_bus.ready is high only in the idle state. Writes and halted
// answers go from idle through ST_DONE to the output register. A restart
// copies the repeat counts of all MAX_ACTORS entries one actor at a time, a
// read and a write state each. A step runs a check pass and then a firing
// pass over the edges in use; every edge pass runs through the single edge
// memory read port and the shared edge unit, a read and an evaluate state per
// edge. Reset clears the halt flag and the repeat counts and resets the csr
// registers; the edge table is undefined until written. A stalled response
// holds in the output register while the next item is worked; the new result
// then waits until the register is free.
// ----------------------------------------------------------------------------
module dataflow_firing_scheduler #(
   parameter int MAX_ACTORS = 8,
   parameter int MAX_EDGES  = 16,
   parameter int RATE_BITS  = 8
) (
   input logic       clock,
   input logic       reset,
   dfs_req_if.sink   req_bus,
   dfs_rsp_if.source rsp_bus,
   dfs_csr_if.sink   csr_bus
);
   import dfs_pkg::*;

   localparam int ACT_W  = (MAX_ACTORS > 1) ? $clog2(MAX_ACTORS) : 1;
   localparam int EDGE_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ACNT_W = $clog2(MAX_ACTORS + 1);
   localparam int ECNT_W = $clog2(MAX_EDGES + 1);
   localparam int AIW    = (ACT_W > ACTOR_W) ? ACT_W : ACTOR_W;
   localparam int EIW    = (EDGE_W > EIDX_W) ? EDGE_W : EIDX_W;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_RST_RD    = 11'b000_0000_0010,
      ST_RST_WR    = 11'b000_0000_0100,
      ST_ACT_RD    = 11'b000_0000_1000,
      ST_ACT_CHK   = 11'b000_0001_0000,
      ST_CHK_RD    = 11'b000_0010_0000,
      ST_CHK_EVAL  = 11'b000_0100_0000,
      ST_FIRE_RD   = 11'b000_1000_0000,
      ST_FIRE_EVAL = 11'b001_0000_0000,
      ST_FIRE_DONE = 11'b010_0000_0000,
      ST_DONE      = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [ACT_W-1:0]    a_ff, a_in;
   logic [EDGE_W-1:0]   e_ff, e_in;
   logic                pending_ff, pending_in;
   logic                over_ff, over_in;
   logic [REPEAT_W-1:0] left_ff, left_in;
   logic                halted_ff, halted_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ACTOR_W-1:0]  res_actor_ff, res_actor_in;
   logic [REPEAT_W-1:0] res_left_ff, res_left_in;
   logic [CAP_W-1:0]    cap_ff;
   logic [EDGES_W-1:0]  edges_ff;
   logic [ACTORS_W-1:0] actors_ff;
   logic                out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [ACTOR_W-1:0]  out_actor_ff;
   logic [REPEAT_W-1:0] out_left_ff;

   logic [CAP_W-1:0]    cap_now;
   logic [ECNT_W-1:0]   edges_now;
   logic [ACNT_W-1:0]   actors_now;
   logic                last_actor;
   logic                last_edge;
   logic                req_fire;
   logic                out_free;
   logic [AIW-1:0]      a_ext;
   logic [AIW-1:0]      aidx_ext;
   logic [EIW-1:0]      eidx_ext;

   logic                edge_wr_en;
   logic                cnt_wr_en;
   logic [EDGE_W-1:0]   cnt_wr_addr;
   logic [TOKEN_W-1:0]  cnt_wr_data;
   logic [ACTOR_W-1:0]  rd_src;
   logic [ACTOR_W-1:0]  rd_dst;
   logic [RATE_BITS-1:0] rd_push;
   logic [RATE_BITS-1:0] rd_pop;
   logic [TOKEN_W-1:0]  rd_count;
   edge_eval_type       eval;

   logic                tgt_wr_en;
   logic [REPEAT_W-1:0] tgt_rd_data;
   logic                left_wr_en;
   logic [REPEAT_W-1:0] left_wr_data;
   logic [REPEAT_W-1:0] left_rd_data;

   // Saturate the register values to what the hardware holds
   assign cap_now    = (cap_ff > CAP_LIMIT) ? CAP_LIMIT : cap_ff;
   assign edges_now  = (32'(edges_ff) > MAX_EDGES) ? ECNT_W'(MAX_EDGES) : ECNT_W'(edges_ff);
   assign actors_now = (32'(actors_ff) > MAX_ACTORS) ? ACNT_W'(MAX_ACTORS)
                                                     : ACNT_W'(actors_ff);
   assign last_actor = ACNT_W'(a_ff) == actors_now - ACNT_W'(1);
   assign last_edge  = ECNT_W'(e_ff) == edges_now - ECNT_W'(1);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign a_ext    = AIW'(a_ff);
   assign aidx_ext = AIW'(req_bus.actor_index);
   assign eidx_ext = EIW'(req_bus.edge_index);

   assign edge_wr_en = req_fire && !halted_ff && (req_bus.action == ACTION_WRITE_EDGE)
                       && (32'(req_bus.edge_index) < MAX_EDGES);
   assign cnt_wr_en   = edge_wr_en || (state_ff == ST_FIRE_EVAL);
   assign cnt_wr_addr = edge_wr_en ? eidx_ext[EDGE_W-1:0] : e_ff;
   assign cnt_wr_data = edge_wr_en ? req_bus.initial_tokens : eval.new_count;

   assign tgt_wr_en = req_fire && !halted_ff && (req_bus.action == ACTION_WRITE_REPEAT)
                      && (32'(req_bus.actor_index) < MAX_ACTORS);
   assign left_wr_en   = (state_ff == ST_RST_WR) || (state_ff == ST_FIRE_DONE);
   assign left_wr_data = (state_ff == ST_RST_WR) ? tgt_rd_data : left_ff - REPEAT_W'(1);

   dfs_edge_mem #(
      .DEPTH     (MAX_EDGES),
      .ADDR_W    (EDGE_W),
      .RATE_BITS (RATE_BITS)
   ) u_edge_mem (
      .clock       (clock),
      .wr_en       (edge_wr_en),
      .wr_addr     (eidx_ext[EDGE_W-1:0]),
      .wr_src      (req_bus.edge_source),
      .wr_dst      (req_bus.edge_target),
      .wr_push     (RATE_BITS'(req_bus.produce_rate)),
      .wr_pop      (RATE_BITS'(req_bus.consume_rate)),
      .cnt_wr_en   (cnt_wr_en),
      .cnt_wr_addr (cnt_wr_addr),
      .cnt_wr_data (cnt_wr_data),
      .rd_addr     (e_ff),
      .rd_src      (rd_src),
      .rd_dst      (rd_dst),
      .rd_push     (rd_push),
      .rd_pop      (rd_pop),
      .rd_count    (rd_count)
   );

   dfs_edge_alu #(
      .ACT_W     (ACT_W),
      .RATE_BITS (RATE_BITS)
   ) u_edge_alu (
      .actor (a_ff),
      .src   (rd_src),
      .dst   (rd_dst),
      .push  (rd_push),
      .pop   (rd_pop),
      .count (rd_count),
      .cap   (cap_now),
      .eval  (eval)
   );

   dfs_cnt_ram #(
      .DEPTH  (MAX_ACTORS),
      .ADDR_W (ACT_W)
   ) u_target_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tgt_wr_en),
      .wr_addr (aidx_ext[ACT_W-1:0]),
      .wr_data (req_bus.repeat_count),
      .rd_addr (a_ff),
      .rd_data (tgt_rd_data)
   );

   dfs_cnt_ram #(
      .DEPTH  (MAX_ACTORS),
      .ADDR_W (ACT_W)
   ) u_left_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (left_wr_en),
      .wr_addr (a_ff),
      .wr_data (left_wr_data),
      .rd_addr (a_ff),
      .rd_data (left_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      e_in          = e_ff;
      pending_in    = pending_ff;
      over_in       = over_ff;
      left_in       = left_ff;
      halted_in     = halted_ff;
      res_status_in = res_status_ff;
      res_actor_in  = res_actor_ff;
      res_left_in   = res_left_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_status_in = STATUS_ACCEPTED;
               res_actor_in  = '0;
               res_left_in   = '0;
               a_in          = '0;
               e_in          = '0;
               pending_in    = 1'b0;
               over_in       = 1'b0;
               state_in      = ST_DONE;
               if (halted_ff) begin
                  res_status_in = STATUS_OVERFLOW;
               end else begin
                  case (req_bus.action)
                     ACTION_WRITE_EDGE: begin
                        if (edge_wr_en && (CAP_W'(req_bus.initial_tokens) >= cap_now)) begin
                           halted_in     = 1'b1;
                           res_status_in = STATUS_OVERFLOW;
                        end
                     end
                     ACTION_WRITE_REPEAT: begin
                        state_in = ST_DONE;
                     end
                     ACTION_RESTART: begin
                        state_in = ST_RST_RD;
                     end
                     default: begin
                        if (actors_now == '0) begin
                           res_status_in = STATUS_ITER_DONE;
                        end else begin
                           state_in = ST_ACT_RD;
                        end
                     end
                  endcase
               end
            end
         end
         ST_RST_RD: begin
            state_in = ST_RST_WR;
         end
         ST_RST_WR: begin
            // copy one target count into the remaining-firings store
            if (a_ff == ACT_W'(MAX_ACTORS - 1)) begin
               state_in = ST_DONE;
            end else begin
               a_in     = a_ff + ACT_W'(1);
               state_in = ST_RST_RD;
            end
         end
         ST_ACT_RD: begin
            state_in = ST_ACT_CHK;
         end
         ST_ACT_CHK: begin
            left_in = left_rd_data;
            e_in    = '0;
            if (left_rd_data == '0) begin
               if (last_actor) begin
                  res_status_in = pending_ff ? STATUS_BLOCKED : STATUS_ITER_DONE;
                  state_in      = ST_DONE;
               end else begin
                  a_in     = a_ff + ACT_W'(1);
                  state_in = ST_ACT_RD;
               end
            end else begin
               pending_in = 1'b1;
               state_in   = (edges_now == '0) ? ST_FIRE_DONE : ST_CHK_RD;
            end
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_EVAL;
         end
         ST_CHK_EVAL: begin
            if (eval.blocked) begin
               // drop this actor and try the next one
               if (last_actor) begin
                  res_status_in = STATUS_BLOCKED;
                  state_in      = ST_DONE;
               end else begin
                  a_in     = a_ff + ACT_W'(1);
                  state_in = ST_ACT_RD;
               end
            end else if (last_edge) begin
               e_in     = '0;
               state_in = ST_FIRE_RD;
            end else begin
               e_in     = e_ff + EDGE_W'(1);
               state_in = ST_CHK_RD;
            end
         end
         ST_FIRE_RD: begin
            state_in = ST_FIRE_EVAL;
         end
         ST_FIRE_EVAL: begin
            over_in = over_ff || eval.over;
            if (last_edge) begin
               state_in = ST_FIRE_DONE;
            end else begin
               e_in     = e_ff + EDGE_W'(1);
               state_in = ST_FIRE_RD;
            end
         end
         ST_FIRE_DONE: begin
            res_status_in = over_ff ? STATUS_OVERFLOW : STATUS_FIRED;
            res_actor_in  = a_ext[ACTOR_W-1:0];
            res_left_in   = left_ff - REPEAT_W'(1);
            if (over_ff) begin
               halted_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         halted_ff  <= 1'b0;
         pending_ff <= 1'b0;
         over_ff    <= 1'b0;
         a_ff       <= '0;
         e_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         halted_ff  <= halted_in;
         pending_ff <= pending_in;
         over_ff    <= over_in;
         a_ff       <= a_in;
         e_ff       <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      res_status_ff <= res_status_in;
      res_actor_ff  <= res_actor_in;
      res_left_ff   <= res_left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         edges_ff  <= EDGES_RESET;
         actors_ff <= ACTORS_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_FIFO_CAPACITY: cap_ff    <= csr_bus.data;
            CSR_EDGES_IN_USE:  edges_ff  <= csr_bus.data[EDGES_W-1:0];
            CSR_ACTORS_IN_USE: actors_ff <= csr_bus.data[ACTORS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Output register: load the finished result once the previous item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         out_status_ff <= res_status_ff;
         out_actor_ff  <= res_actor_ff;
         out_left_ff   <= res_left_ff;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.fired_actor  = out_actor_ff;
   assign rsp_bus.firings_left = out_left_ff;

endmodule

@@ dv/tb_dataflow_firing_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dataflow_firing_scheduler
// Self-checking bench for the dataflow firing scheduler. A scoreboard keeps
// its own token counts, repeat counts and halt flag, predicts the answer to
// every accepted request item and checks the response items in order. The
// stimulus builds small graphs, runs iterations over them with noise mixed
// in, and ends with one deliberate overflow followed by halted traffic.
// ----------------------------------------------------------------------------
import dfs_pkg::*;

localparam int NUM_EDGES  = 16;
localparam int NUM_ACTORS = 8;

typedef struct packed {
   logic [ACTION_W-1:0]  action;
   logic [EIDX_W-1:0]    edge_index;
   logic [ACTOR_W-1:0]   edge_source;
   logic [ACTOR_W-1:0]   edge_target;
   logic [RATE_IN_W-1:0] produce_rate;
   logic [RATE_IN_W-1:0] consume_rate;
   logic [TOKEN_W-1:0]   initial_tokens;
   logic [ACTOR_W-1:0]   actor_index;
   logic [REPEAT_W-1:0]  repeat_count;
} sched_req_t;

typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [ACTOR_W-1:0]  actor;
   logic [REPEAT_W-1:0] left;
} sched_rsp_t;

class sched_scoreboard;
   logic [ACTOR_W-1:0]   src_tab  [NUM_EDGES];
   logic [ACTOR_W-1:0]   dst_tab  [NUM_EDGES];
   logic [RATE_IN_W-1:0] push_tab [NUM_EDGES];
   logic [RATE_IN_W-1:0] pop_tab  [NUM_EDGES];
   logic [TOKEN_W-1:0]   tokens   [NUM_EDGES];
   logic [REPEAT_W-1:0]  rep_target [NUM_ACTORS];
   logic [REPEAT_W-1:0]  rep_left   [NUM_ACTORS];
   logic [NUM_EDGES-1:0] written;
   bit                   halted;
   logic [CAP_W-1:0]     cap_reg;
   logic [EDGES_W-1:0]   edges_reg;
   logic [ACTORS_W-1:0]  actors_reg;
   sched_rsp_t           expected_answers[$];
   int                   errors;
   int                   tally[5];

   function new();
      for (int e = 0; e < NUM_EDGES; e++) begin
         src_tab[e] = '0; dst_tab[e] = '0; push_tab[e] = '0; pop_tab[e] = '0;
         tokens[e] = '0;
      end
      for (int a = 0; a < NUM_ACTORS; a++) begin
         rep_target[a] = '0;
         rep_left[a]   = '0;
      end
      written    = '0;
      halted     = 1'b0;
      cap_reg    = CAP_RESET;
      edges_reg  = EDGES_RESET;
      actors_reg = ACTORS_RESET;
      errors     = 0;
      for (int s = 0; s < 5; s++) tally[s] = 0;
   endfunction

   function int capacity();
      return (cap_reg > CAP_LIMIT) ? int'(CAP_LIMIT) : int'(cap_reg);
   endfunction

   function int active_edges();
      return (edges_reg > NUM_EDGES) ? NUM_EDGES : int'(edges_reg);
   endfunction

   function int active_actors();
      return (actors_reg > NUM_ACTORS) ? NUM_ACTORS : int'(actors_reg);
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_FIFO_CAPACITY: cap_reg    = value;
         CSR_EDGES_IN_USE:  edges_reg  = value[EDGES_W-1:0];
         CSR_ACTORS_IN_USE: actors_reg = value[ACTORS_W-1:0];
         default: ;
      endcase
   endfunction

   // Work out the answer to one item; state changes only when commit is set
   function sched_rsp_t schedule_step(sched_req_t it, bit commit);
      sched_rsp_t          r;
      logic [TOKEN_W-1:0]  tok  [NUM_EDGES];
      logic [REPEAT_W-1:0] left [NUM_ACTORS];
      int                  cap, ne, na, c;
      bit                  waiting, found, ok, over;
      r       = '0;
      cap     = capacity();
      ne      = active_edges();
      na      = active_actors();
      waiting = 1'b0;
      found   = 1'b0;
      over    = 1'b0;
      if (halted) begin
         r.status = STATUS_OVERFLOW;
      end else begin
         case (it.action)
            ACTION_WRITE_EDGE: begin
               if (int'(it.initial_tokens) >= cap) r.status = STATUS_OVERFLOW;
               if (commit) begin
                  src_tab[it.edge_index]  = it.edge_source;
                  dst_tab[it.edge_index]  = it.edge_target;
                  push_tab[it.edge_index] = it.produce_rate;
                  pop_tab[it.edge_index]  = it.consume_rate;
                  tokens[it.edge_index]   = it.initial_tokens;
                  written[it.edge_index]  = 1'b1;
                  if (r.status == STATUS_OVERFLOW) halted = 1'b1;
               end
            end
            ACTION_WRITE_REPEAT: begin
               if (commit) rep_target[it.actor_index] = it.repeat_count;
            end
            ACTION_RESTART: begin
               if (commit) rep_left = rep_target;
            end
            default: begin
               tok      = tokens;
               left     = rep_left;
               r.status = STATUS_ITER_DONE;
               for (int a = 0; a < na; a++) begin
                  if (!found && left[a] != 0) begin
                     waiting = 1'b1;
                     ok      = 1'b1;
                     for (int e = 0; e < ne; e++)
                        if (dst_tab[e] == a && pop_tab[e] > tok[e]) ok = 1'b0;
                     if (ok) begin
                        // consume first, then produce: self-loops see the drop
                        for (int e = 0; e < ne; e++)
                           if (dst_tab[e] == a) tok[e] = tok[e] - pop_tab[e];
                        for (int e = 0; e < ne; e++) begin
                           if (src_tab[e] == a) begin
                              c = tok[e] + push_tab[e];
                              if (c >= cap) over = 1'b1;
                              if (c > int'(TOKEN_MAX)) tok[e] = TOKEN_MAX;
                              else tok[e] = c;
                           end
                        end
                        left[a]  = left[a] - 1'b1;
                        r.status = over ? STATUS_OVERFLOW : STATUS_FIRED;
                        r.actor  = a;
                        r.left   = left[a];
                        waiting  = 1'b0;
                        found    = 1'b1;
                     end
                  end
               end
               if (waiting) r.status = STATUS_BLOCKED;
               if (commit) begin
                  tokens   = tok;
                  rep_left = left;
                  if (over) halted = 1'b1;
               end
            end
         endcase
      end
      return r;
   endfunction

   // Reshape an item so that it neither halts the block nor reads an edge
   // entry that was never loaded
   function sched_req_t tame(sched_req_t it);
      sched_req_t t;
      sched_rsp_t r;
      int         ne, cap, hot;
      t   = it;
      ne  = active_edges();
      cap = capacity();
      if (halted) return t;
      if (t.action == ACTION_STEP) begin
         for (int e = ne - 1; e >= 0; e--) begin
            if (!written[e]) begin
               t.action     = ACTION_WRITE_EDGE;
               t.edge_index = e;
            end
         end
      end
      r = schedule_step(t, 1'b0);
      while (r.status == STATUS_OVERFLOW) begin
         if (t.action == ACTION_WRITE_EDGE) begin
            if (cap == 0) t.action = ACTION_RESTART;
            else t.initial_tokens = $urandom_range(cap - 1, 0);
         end else begin
            // drain the firing actor's first output edge that pushes or is full instead
            hot = -1;
            for (int e = ne - 1; e >= 0; e--)
               if (src_tab[e] == r.actor && (push_tab[e] != 0 || int'(tokens[e]) >= cap))
                  hot = e;
            if (hot < 0) begin
               t.action = ACTION_RESTART;
            end else begin
               t.action         = ACTION_WRITE_EDGE;
               t.edge_index     = hot;
               t.edge_source    = src_tab[hot];
               t.edge_target    = dst_tab[hot];
               t.produce_rate   = '0;
               t.consume_rate   = pop_tab[hot];
               t.initial_tokens = '0;
            end
         end
         r = schedule_step(t, 1'b0);
      end
      return t;
   endfunction

   function void note_input(sched_req_t it);
      expected_answers.push_back(schedule_step(it, 1'b1));
   endfunction

   function void check_result(sched_rsp_t got);
      sched_rsp_t want;
      if (expected_answers.size() == 0) begin
         $error("unexpected response: status %0d actor %0d left %0d",
                got.status, got.actor, got.left);
         errors++;
         return;
      end
      want = expected_answers.pop_front();
      if (want.status <= STATUS_OVERFLOW) tally[want.status]++;
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
      if (got.actor !== want.actor) begin
         $error("fired_actor: expected %0d, got %0d", want.actor, got.actor);
         errors++;
      end
      if (got.left !== want.left) begin
         $error("firings_left: expected %0d, got %0d", want.left, got.left);
         errors++;
      end
   endfunction
endclass

module tb_dataflow_firing_scheduler;

   localparam int ITEM_TARGET   = 900;
   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 50;

   logic clock = 1'b0;
   logic reset;

   dfs_req_if req_bus ();
   dfs_rsp_if rsp_bus ();
   dfs_csr_if csr_bus ();

   dataflow_firing_scheduler dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sched_scoreboard sb = new();

   int items_sent = 0;
   int csr_writes = 0;
   int phases     = 0;
   int burst_left = 0;
   bit no_idle    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sched_req_t plain_item(logic [ACTION_W-1:0] act);
      sched_req_t t;
      t        = '0;
      t.action = act;
      return t;
   endfunction

   function automatic sched_req_t link_item(int idx, int src, int dst, int push, int pop,
                                            int tok);
      sched_req_t t;
      t                = plain_item(ACTION_WRITE_EDGE);
      t.edge_index     = idx;
      t.edge_source    = src;
      t.edge_target    = dst;
      t.produce_rate   = push;
      t.consume_rate   = pop;
      t.initial_tokens = tok;
      return t;
   endfunction

   function automatic sched_req_t count_item(int a, int n);
      sched_req_t t;
      t              = plain_item(ACTION_WRITE_REPEAT);
      t.actor_index  = a;
      t.repeat_count = n;
      return t;
   endfunction

   function automatic sched_req_t random_item();
      sched_req_t t;
      t.action         = $urandom_range(0, 3);
      t.edge_index     = $urandom_range(0, 15);
      t.edge_source    = $urandom_range(0, 7);
      t.edge_target    = $urandom_range(0, 7);
      t.produce_rate   = $urandom_range(0, 255);
      t.consume_rate   = $urandom_range(0, 255);
      t.initial_tokens = $urandom_range(0, 1023);
      t.actor_index    = $urandom_range(0, 7);
      t.repeat_count   = $urandom_range(0, 255);
      return t;
   endfunction

   // Mostly small values, now and then the full 8-bit range
   function automatic int pick_rate();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
   endfunction

   task automatic send(sched_req_t it, bit raw);
      sched_req_t t;
      int         gap;
      if (burst_left == 0) begin
         gap        = no_idle ? 0 : $urandom_range(0, 12);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      t = raw ? it : sb.tame(it);
      req_bus.action         <= t.action;
      req_bus.edge_index     <= t.edge_index;
      req_bus.edge_source    <= t.edge_source;
      req_bus.edge_target    <= t.edge_target;
      req_bus.produce_rate   <= t.produce_rate;
      req_bus.consume_rate   <= t.consume_rate;
      req_bus.initial_tokens <= t.initial_tokens;
      req_bus.actor_index    <= t.actor_index;
      req_bus.repeat_count   <= t.repeat_count;
      req_bus.valid          <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_input(t);
      items_sent++;
   endtask

   // Registers change only with the block idle and every answer collected
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.set_reg(idx, value);
      csr_bus.valid <= 1'b0;
      csr_writes++;
      burst_left = 0;
   endtask

   task automatic run_directed();
      send(plain_item(ACTION_STEP), 1'b0);
      write_reg(CSR_FIFO_CAPACITY, 11'd2047);
      write_reg(CSR_EDGES_IN_USE, 11'd2);
      write_reg(CSR_ACTORS_IN_USE, 11'd3);
      send(link_item(0, 0, 1, 255, 255, 0), 1'b0);
      send(link_item(1, 1, 2, 0, 0, 1023), 1'b0);
      send(count_item(7, 255), 1'b0);
      send(count_item(0, 2), 1'b0);
      send(count_item(1, 3), 1'b0);
      send(count_item(2, 1), 1'b0);
      send(plain_item(ACTION_RESTART), 1'b0);
      // two firings each of actors 0 and 1, one of actor 2, then starved
      repeat (7) send(plain_item(ACTION_STEP), 1'b0);
      write_reg(CSR_ACTORS_IN_USE, 11'd0);
      send(plain_item(ACTION_STEP), 1'b0);
      write_reg(CSR_ACTORS_IN_USE, 11'd15);
      send(plain_item(ACTION_RESTART), 1'b0);
      send(plain_item(ACTION_STEP), 1'b0);
   endtask

   task automatic run_phase();
      logic [CSR_DATA_W-1:0] value;
      int                    ne, na, span, n, owed;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 5))
            0: value = 11'd2;
            1: value = CAP_LIMIT;
            2: value = $urandom_range(1025, 2047);
            3: value = 11'd1;
            default: value = $urandom_range(8, 64);
         endcase
         write_reg(CSR_FIFO_CAPACITY, value);
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 5))
            0: value = 11'd0;
            1: value = 11'd16;
            2: value = $urandom_range(17, 31);
            default: value = $urandom_range(1, 8);
         endcase
         write_reg(CSR_EDGES_IN_USE, value);
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 5))
            0: value = 11'd0;
            1: value = 11'd8;
            2: value = $urandom_range(9, 15);
            default: value = $urandom_range(1, 6);
         endcase
         write_reg(CSR_ACTORS_IN_USE, value);
      end
      ne   = sb.active_edges();
      na   = sb.active_actors();
      span = (na == 0) ? NUM_ACTORS : na;
      for (int e = 0; e < ne; e++) begin
         if ($urandom_range(0, 7) != 0)
            send(link_item(e, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                           pick_rate(), pick_rate(),
                           ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 6)), 1'b0);
      end
      owed = 0;
      for (int a = 0; a < NUM_ACTORS; a++) begin
         n = pick_rate();
         if (a < na) owed += n;
         send(count_item(a, n), 1'b0);
      end
      send(plain_item(ACTION_RESTART), 1'b0);
      if (owed > 40) owed = 40;
      repeat (owed + 2) begin
         if ($urandom_range(0, 9) == 0) send(random_item(), 1'b0);
         else send(plain_item(ACTION_STEP), 1'b0);
      end
      phases++;
   endtask

   // Halt the block once, by a load or by a firing, then keep it busy
   task automatic run_halt_phase();
      int cap;
      if ($urandom_range(0, 1) == 0) begin
         write_reg(CSR_FIFO_CAPACITY, $urandom_range(0, 16));
         cap = sb.capacity();
         send(link_item($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
                        pick_rate(), pick_rate(), $urandom_range(cap, 1023)), 1'b1);
      end else begin
         write_reg(CSR_FIFO_CAPACITY, CAP_LIMIT);
         write_reg(CSR_EDGES_IN_USE, 11'd1);
         write_reg(CSR_ACTORS_IN_USE, 11'd2);
         // actor 1 pushes past the top of the count, which clamps
         send(link_item(0, 1, 0, 255, 0, 1000), 1'b1);
         send(count_item(0, 0), 1'b1);
         send(count_item(1, 3), 1'b1);
         send(plain_item(ACTION_RESTART), 1'b1);
         send(plain_item(ACTION_STEP), 1'b1);
      end
      repeat (8) send(random_item(), 1'b1);
   endtask

   initial begin
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.action         <= '0;
      req_bus.edge_index     <= '0;
      req_bus.edge_source    <= '0;
      req_bus.edge_target    <= '0;
      req_bus.produce_rate   <= '0;
      req_bus.consume_rate   <= '0;
      req_bus.initial_tokens <= '0;
      req_bus.actor_index    <= '0;
      req_bus.repeat_count   <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= '0;
      csr_bus.data           <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      while (items_sent < ITEM_TARGET) run_phase();
      run_halt_phase();
      req_bus.valid <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d request items and %0d register writes over %0d graph phases",
               items_sent, csr_writes, phases);
      $display("Answers: %0d fired, %0d complete, %0d blocked, %0d overflow, %0d accepted",
               sb.tally[STATUS_FIRED], sb.tally[STATUS_ITER_DONE], sb.tally[STATUS_BLOCKED],
               sb.tally[STATUS_OVERFLOW], sb.tally[STATUS_ACCEPTED]);
      if (sb.errors == 0 && sb.expected_answers.size() == 0) begin
         $display("tb_dataflow_firing_scheduler passed");
      end else begin
         $display("tb_dataflow_firing_scheduler failed");
      end
      $finish;
   end

   // Response side: check each item, stall on a pattern that shifts over time
   initial begin
      int         stall_left;
      int         stall_mode;
      int         cyc;
      sched_rsp_t got;
      stall_left = 0;
      stall_mode = 0;
      cyc        = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.actor  = rsp_bus.fired_actor;
            got.left   = rsp_bus.firings_left;
            sb.check_result(got);
         end
         cyc++;
         if (cyc % 256 == 0) stall_mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            case (stall_mode)
               1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
               2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 40);
               default: ;
            endcase
         end
      end
   end

   // Watchdog: give up after a long stretch with no handshake anywhere
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no handshake for %0d cycles", quiet);
      $display("tb_dataflow_firing_scheduler failed");
      $finish;
   end

endmodule
